>>> hw/rtl/wsc_pkg.sv
`default_nettype none
package wsc_pkg;
    localparam int CORDIC_STEPS = 24;
    localparam int ZW = 34;
    localparam int DW = 40;
    localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [ZW-1:0] HALF_TURN = 34'sd2147483648;
    localparam logic signed [DW-1:0] INV_GAIN_Q30 = 40'sd652032874;

    localparam logic [2:0] REG_LEFT_X = 3'd0;
    localparam logic [2:0] REG_RIGHT_X = 3'd1;
    localparam logic [2:0] REG_TOP_Y = 3'd2;
    localparam logic [2:0] REG_BOTTOM_Y = 3'd3;
    localparam logic [2:0] REG_ARRIVE_RADIUS = 3'd4;
    localparam logic [2:0] REG_CRUISE_SPEED = 3'd5;
    localparam logic [2:0] REG_MIN_SPEED = 3'd6;
    localparam logic [2:0] REG_TURN_STEP = 3'd7;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                5'd0: r = 34'sd536870912;
                5'd1: r = 34'sd316933406;
                5'd2: r = 34'sd167458907;
                5'd3: r = 34'sd85004756;
                5'd4: r = 34'sd42667331;
                5'd5: r = 34'sd21354465;
                5'd6: r = 34'sd10680862;
                5'd7: r = 34'sd5340245;
                5'd8: r = 34'sd2670163;
                5'd9: r = 34'sd1335087;
                5'd10: r = 34'sd667544;
                5'd11: r = 34'sd333772;
                5'd12: r = 34'sd166886;
                5'd13: r = 34'sd83443;
                5'd14: r = 34'sd41722;
                5'd15: r = 34'sd20861;
                5'd16: r = 34'sd10430;
                5'd17: r = 34'sd5215;
                5'd18: r = 34'sd2608;
                5'd19: r = 34'sd1304;
                5'd20: r = 34'sd652;
                5'd21: r = 34'sd326;
                5'd22: r = 34'sd163;
                5'd23: r = 34'sd81;
                default: r = '0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/wsc_if.sv
`default_nettype none
interface wsc_if #(parameter int W = 8);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/waypoint_steering_controller.sv
// channel | dir | word layout (msb..lsb)
// pose    | in  | pose_valid, robot_x, robot_y, heading
// drive   | out | right_drive, left_drive, goal_corner, arrived
// cfg     | in  | index[2:0], value[15:0]
// A tracked pose goes from acceptance to a valid word through difference, square,
// compare, 24 atan2 CORDIC steps (none for the zero vector), angle setup, 24 cosine
// CORDIC steps, then multiply, clamp, bend and output; both CORDIC runs share one
// add/shift stage. A missing pose goes straight to output; an arrival after compare.
// Reset clears the goal index and the registers to their defaults.
// A finished word waits in the output register; pose is not taken meanwhile.
`default_nettype none
module waypoint_steering_controller #(
    parameter int COORD_BITS = 11,
    parameter int ANGLE_BITS = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    wsc_if.sink pose,
    wsc_if.source drive,
    wsc_if.sink cfg
);
    localparam int IW = 1 + 2 * COORD_BITS + ANGLE_BITS;
    localparam int SQW = 2 * COORD_BITS + 3;
    localparam logic [3:0] S_IDLE = 4'd0, S_DIFF = 4'd1, S_SQ = 4'd2, S_CMP = 4'd3,
        S_ATAN = 4'd4, S_REL = 4'd5, S_COS = 4'd6, S_CQ = 4'd7, S_MUL = 4'd8,
        S_BEND = 4'd9, S_OUT = 4'd10;

    logic [3:0] state_reg;
    logic [4:0] step_reg;
    logic [1:0] goal_reg;
    logic [COORD_BITS-1:0] left_x_reg, right_x_reg, top_y_reg, bottom_y_reg, radius_reg;
    logic [6:0] cruise_reg, min_reg;
    logic [5:0] turn_reg;
    logic [COORD_BITS-1:0] rx_reg, ry_reg;
    logic signed [ANGLE_BITS-1:0] head_reg, rel_reg;
    logic signed [COORD_BITS:0] dx_reg, dy_reg;
    logic signed [SQW-1:0] acc_reg;
    logic signed [wsc_pkg::DW-1:0] x_reg, y_reg;
    logic signed [wsc_pkg::ZW-1:0] z_reg;
    logic neg_reg;
    logic signed [23:0] s_reg;
    logic signed [8:0] fr_reg, fl_reg;
    logic arrived_reg, ovalid_reg;

    assign cfg.ready = 1'b1;
    assign pose.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign drive.valid = ovalid_reg;
    assign drive.data = {fr_reg, fl_reg, goal_reg, arrived_reg};

    wire logic [2:0] cfg_idx = cfg.data[18:16];
    wire logic [15:0] cfg_val = cfg.data[15:0];

    // shared CORDIC stage
    logic signed [wsc_pkg::DW-1:0] xs, ys;
    logic signed [wsc_pkg::ZW-1:0] at;
    logic dir_pos;
    always_comb
    begin
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        at = wsc_pkg::atan_entry(step_reg);
        dir_pos = (state_reg == S_ATAN) ? !y_reg[wsc_pkg::DW-1] : !z_reg[wsc_pkg::ZW-1];
    end

    logic signed [ANGLE_BITS-1:0] rel_w;
    logic signed [wsc_pkg::ZW-1:0] brg;
    logic signed [wsc_pkg::DW-1:0] xn;
    logic signed [16:0] cq;
    logic signed [15:0] cs;
    logic signed [ANGLE_BITS+5:0] piv;
    logic signed [23:0] lim, abs_s;
    logic signed [6:0] off;
    logic signed [24:0] vr, vl;
    always_comb
    begin
        brg = (z_reg + (wsc_pkg::ZW'(1) <<< (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
        rel_w = ANGLE_BITS'(brg) - head_reg;
        if (rel_w == {1'b1, {(ANGLE_BITS-1){1'b0}}})
            rel_w = rel_w; // -pi stays as bit pattern; handled as +pi below
        xn = neg_reg ? -x_reg : x_reg;
        cq = 17'((xn + 40'sd16384) >>> 15);
        if (cq > 17'sd32767)
            cs = 16'sd32767;
        else if (cq < -17'sd32768)
            cs = -16'sd32768;
        else
            cs = 16'(cq);
        piv = (ANGLE_BITS+6)'(24) * (ANGLE_BITS+6)'(rel_reg)
            - ((ANGLE_BITS+6)'(1) <<< ANGLE_BITS);
        if (rel_reg == {1'b1, {(ANGLE_BITS-1){1'b0}}})
            piv = (ANGLE_BITS+6)'(24) * ((ANGLE_BITS+6)'(1) <<< (ANGLE_BITS-1))
                - ((ANGLE_BITS+6)'(1) <<< ANGLE_BITS);
        lim = 24'(min_reg) <<< 15;
        abs_s = s_reg[23] ? -s_reg : s_reg;
        if (s_reg > 0)
            off = (piv < 0) ? -7'(turn_reg) : ((piv > 0) ? 7'(turn_reg) : 7'sd0);
        else
            off = (piv > 0) ? -7'(turn_reg) : ((piv < 0) ? 7'(turn_reg) : 7'sd0);
        vr = (25'(off) <<< 15) + 25'(s_reg);
        vl = (-(25'(off)) <<< 15) + 25'(s_reg);
    end

    function automatic logic signed [8:0] trunc15(input logic signed [24:0] v);
        logic [24:0] m;
        begin
            m = v[24] ? 25'(-v) : 25'(v);
            m = m >> 15;
            return v[24] ? -9'(m) : 9'(m);
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= '0;
            goal_reg <= '0;
            ovalid_reg <= 1'b0;
            left_x_reg <= COORD_BITS'(200);
            right_x_reg <= COORD_BITS'(1720);
            top_y_reg <= COORD_BITS'(200);
            bottom_y_reg <= COORD_BITS'(880);
            radius_reg <= COORD_BITS'(100);
            cruise_reg <= 7'd50;
            min_reg <= 7'd15;
            turn_reg <= 6'd10;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg_idx)
                    wsc_pkg::REG_LEFT_X: left_x_reg <= COORD_BITS'(cfg_val);
                    wsc_pkg::REG_RIGHT_X: right_x_reg <= COORD_BITS'(cfg_val);
                    wsc_pkg::REG_TOP_Y: top_y_reg <= COORD_BITS'(cfg_val);
                    wsc_pkg::REG_BOTTOM_Y: bottom_y_reg <= COORD_BITS'(cfg_val);
                    wsc_pkg::REG_ARRIVE_RADIUS: radius_reg <= COORD_BITS'(cfg_val);
                    wsc_pkg::REG_CRUISE_SPEED: cruise_reg <= cfg_val[6:0];
                    wsc_pkg::REG_MIN_SPEED: min_reg <= cfg_val[6:0];
                    wsc_pkg::REG_TURN_STEP: turn_reg <= cfg_val[5:0];
                    default: ;
                endcase
            end
            if (ovalid_reg && drive.ready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (pose.valid && pose.ready)
                    begin
                        rx_reg <= pose.data[IW-2 -: COORD_BITS];
                        ry_reg <= pose.data[ANGLE_BITS+COORD_BITS-1 -: COORD_BITS];
                        head_reg <= pose.data[ANGLE_BITS-1:0];
                        fr_reg <= '0;
                        fl_reg <= '0;
                        arrived_reg <= 1'b0;
                        state_reg <= pose.data[IW-1] ? S_DIFF : S_OUT;
                    end
                S_DIFF:
                begin
                    dx_reg <= $signed({1'b0, (goal_reg == 2'd0 || goal_reg == 2'd3)
                        ? left_x_reg : right_x_reg}) - $signed({1'b0, rx_reg});
                    dy_reg <= $signed({1'b0, goal_reg[1] ? bottom_y_reg : top_y_reg})
                        - $signed({1'b0, ry_reg});
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    acc_reg <= SQW'(dx_reg) * SQW'(dx_reg) + SQW'(dy_reg) * SQW'(dy_reg)
                        - SQW'($signed({1'b0, radius_reg})) * SQW'($signed({1'b0, radius_reg}));
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    step_reg <= '0;
                    if (acc_reg < 0)
                    begin
                        goal_reg <= goal_reg + 2'd1;
                        arrived_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        // pre-rotate into the right half plane
                        if (dx_reg < 0 && !dy_reg[COORD_BITS])
                        begin
                            x_reg <= wsc_pkg::DW'(dy_reg) <<< 20;
                            y_reg <= -(wsc_pkg::DW'(dx_reg) <<< 20);
                            z_reg <= wsc_pkg::QUARTER_TURN;
                        end
                        else if (dx_reg < 0)
                        begin
                            x_reg <= -(wsc_pkg::DW'(dy_reg) <<< 20);
                            y_reg <= wsc_pkg::DW'(dx_reg) <<< 20;
                            z_reg <= -wsc_pkg::QUARTER_TURN;
                        end
                        else
                        begin
                            x_reg <= wsc_pkg::DW'(dx_reg) <<< 20;
                            y_reg <= wsc_pkg::DW'(dy_reg) <<< 20;
                            z_reg <= '0;
                        end
                        state_reg <= (dx_reg == 0 && dy_reg == 0) ? S_REL : S_ATAN;
                    end
                end
                S_ATAN, S_COS:
                begin
                    if (dir_pos == (state_reg == S_ATAN))
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                    end
                    else
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                    end
                    z_reg <= (dir_pos == (state_reg == S_ATAN)) ? z_reg + at : z_reg - at;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(wsc_pkg::CORDIC_STEPS - 1))
                        state_reg <= (state_reg == S_ATAN) ? S_REL : S_CQ;
                end
                S_REL:
                begin
                    // z_reg is 0 for the zero vector
                    rel_reg <= rel_w;
                    step_reg <= '0;
                    x_reg <= wsc_pkg::INV_GAIN_Q30;
                    y_reg <= '0;
                    if (rel_w == {1'b1, {(ANGLE_BITS-1){1'b0}}})
                    begin
                        z_reg <= '0;
                        neg_reg <= 1'b1;
                    end
                    else if ((wsc_pkg::ZW'(rel_w) <<< (32 - ANGLE_BITS)) > wsc_pkg::QUARTER_TURN)
                    begin
                        z_reg <= (wsc_pkg::ZW'(rel_w) <<< (32 - ANGLE_BITS)) - wsc_pkg::HALF_TURN;
                        neg_reg <= 1'b1;
                    end
                    else if ((wsc_pkg::ZW'(rel_w) <<< (32 - ANGLE_BITS)) < -wsc_pkg::QUARTER_TURN)
                    begin
                        z_reg <= (wsc_pkg::ZW'(rel_w) <<< (32 - ANGLE_BITS)) + wsc_pkg::HALF_TURN;
                        neg_reg <= 1'b1;
                    end
                    else
                    begin
                        z_reg <= wsc_pkg::ZW'(rel_w) <<< (32 - ANGLE_BITS);
                        neg_reg <= 1'b0;
                    end
                    state_reg <= S_COS;
                end
                S_CQ:
                begin
                    s_reg <= 24'($signed({1'b0, cruise_reg})) * 24'(cs);
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (abs_s < lim)
                        s_reg <= s_reg[23] ? -lim : lim;
                    state_reg <= S_BEND;
                end
                S_BEND:
                begin
                    fr_reg <= trunc15(vr);
                    fl_reg <= trunc15(vl);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !drive.valid) else $error("busy with word pending");
    a_arrive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (drive.valid && arrived_reg) |-> (fr_reg == 0 && fl_reg == 0))
        else $error("arrival with drive");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (drive.valid && !drive.ready) |=> $stable(drive.data)) else $error("word changed");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ATAN || state_reg == S_COS) |-> (step_reg < 5'd24))
        else $error("step overrun");
endmodule
`default_nettype wire

>>> test/waypoint_steering_controller_tb.sv
`default_nettype none
module waypoint_steering_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES = 8;

    logic clk;
    logic rst_n;
    int   mismatches = 0;
    int   drives_seen = 0;
    int   arrivals_seen = 0;
    int   blind_frames = 0;
    bit   hold_req = 0;
    bit   send_steady = 0;
    bit   recv_steady = 0;

    wsc_if #(.W(39)) pose ();
    wsc_if #(.W(21)) drive ();
    wsc_if #(.W(19)) cfg ();

    waypoint_steering_controller u_top (
        .clk(clk),
        .rst_n(rst_n),
        .pose(pose.sink),
        .drive(drive.source),
        .cfg(cfg.sink)
    );

    typedef struct packed {
        logic [8:0] right_drive;
        logic [8:0] left_drive;
        logic [1:0] goal_corner;
        logic       arrived;
    } drive_word_t;

    class steering_predictor;
        longint      arc_tab[24];
        logic [10:0] corner_left, corner_right, corner_top, corner_bottom, radius;
        logic [6:0]  cruise, floor_speed;
        logic [5:0]  bend;
        logic [1:0]  goal;
        drive_word_t expected_drives[$];

        function new();
            arc_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                        10680862, 5340245, 2670163, 1335087, 667544, 333772,
                        166886, 83443, 41722, 20861, 10430, 5215,
                        2608, 1304, 652, 326, 163, 81};
            corner_left = 200; corner_right = 1720; corner_top = 200;
            corner_bottom = 880; radius = 100; cruise = 50; floor_speed = 15;
            bend = 10; goal = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] value);
            case (idx)
                wsc_pkg::REG_LEFT_X: corner_left = value[10:0];
                wsc_pkg::REG_RIGHT_X: corner_right = value[10:0];
                wsc_pkg::REG_TOP_Y: corner_top = value[10:0];
                wsc_pkg::REG_BOTTOM_Y: corner_bottom = value[10:0];
                wsc_pkg::REG_ARRIVE_RADIUS: radius = value[10:0];
                wsc_pkg::REG_CRUISE_SPEED: cruise = value[6:0];
                wsc_pkg::REG_MIN_SPEED: floor_speed = value[6:0];
                wsc_pkg::REG_TURN_STEP: bend = value[5:0];
                default: ;
            endcase
        endfunction

        function longint goal_x();
            return (goal == 0 || goal == 3) ? longint'(corner_left) : longint'(corner_right);
        endfunction

        function longint goal_y();
            return (goal < 2) ? longint'(corner_top) : longint'(corner_bottom);
        endfunction

        function longint bearing_to(longint dx, longint dy);
            longint x, y, z, t, xs, ys;
            x = dx * (64'sd1 <<< 20);
            y = dy * (64'sd1 <<< 20);
            z = 0;
            if (dx == 0 && dy == 0)
                return 0;
            // pre-rotate into the right half plane
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    t = x; x = y; y = -t; z = 64'sd1073741824;
                end
                else
                begin
                    t = x; x = -y; y = t; z = -64'sd1073741824;
                end
            end
            for (int i = 0; i < 24; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x += ys; y -= xs; z += arc_tab[i];
                end
                else
                begin
                    x -= ys; y += xs; z -= arc_tab[i];
                end
            end
            return (z + 64'sd32768) >>> 16;
        endfunction

        function longint cosine_q15(longint rel);
            longint x, y, z, xs, ys, c;
            bit flip;
            z = rel * 65536;
            x = 652032874;
            y = 0;
            flip = 0;
            if (z > 64'sd1073741824)
            begin
                z -= 64'sd2147483648; flip = 1;
            end
            else if (z < -64'sd1073741824)
            begin
                z += 64'sd2147483648; flip = 1;
            end
            for (int i = 0; i < 24; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x -= ys; y += xs; z -= arc_tab[i];
                end
                else
                begin
                    x += ys; y -= xs; z += arc_tab[i];
                end
            end
            if (flip)
                x = -x;
            c = (x + 16384) >>> 15;
            if (c > 32767) c = 32767;
            if (c < -32768) c = -32768;
            return c;
        endfunction

        function longint wheel(longint offset, longint s);
            longint v;
            v = offset * 32768 + s;
            return (v >= 0) ? (v >>> 15) : -((-v) >>> 15);
        endfunction

        function void note_pose(logic seen, logic [10:0] rx, logic [10:0] ry,
                                logic signed [15:0] hd);
            drive_word_t w;
            longint dx, dy, r, rel, s, lim, piv, off, t;
            w = '0;
            if (seen)
            begin
                dx = goal_x() - longint'(rx);
                dy = goal_y() - longint'(ry);
                r = longint'(radius);
                if (dx * dx + dy * dy < r * r)
                begin
                    goal = goal + 2'd1;
                    w.arrived = 1'b1;
                end
                else
                begin
                    rel = (bearing_to(dx, dy) - longint'(hd)) & 64'hFFFF;
                    if (rel >= 32768) rel -= 65536;
                    if (rel == -32768) rel = 32768;
                    s = longint'(cruise) * cosine_q15(rel);
                    lim = longint'(floor_speed) * 32768;
                    if (((s < 0) ? -s : s) < lim)
                        s = (s < 0) ? -lim : lim;
                    piv = 24 * rel - 65536;
                    t = longint'(bend);
                    off = 0;
                    // a zero speed bends as a reversing one
                    if (s > 0)
                        off = (piv < 0) ? -t : (piv > 0) ? t : 0;
                    else
                        off = (piv > 0) ? -t : (piv < 0) ? t : 0;
                    w.right_drive = 9'(wheel(off, s));
                    w.left_drive = 9'(wheel(-off, s));
                end
            end
            w.goal_corner = goal;
            expected_drives.push_back(w);
        endfunction

        function string check_drive(drive_word_t got);
            drive_word_t want;
            string msg;
            if (expected_drives.size() == 0)
                return $sformatf("unexpected drive word %h", got);
            want = expected_drives.pop_front();
            msg = "";
            if (got.right_drive !== want.right_drive)
                msg = {msg, $sformatf(" right %0d/%0d", $signed(got.right_drive),
                                      $signed(want.right_drive))};
            if (got.left_drive !== want.left_drive)
                msg = {msg, $sformatf(" left %0d/%0d", $signed(got.left_drive),
                                      $signed(want.left_drive))};
            if (got.goal_corner !== want.goal_corner)
                msg = {msg, $sformatf(" corner %0d/%0d", got.goal_corner, want.goal_corner)};
            if (got.arrived !== want.arrived)
                msg = {msg, $sformatf(" arrived %b/%b", got.arrived, want.arrived)};
            return msg;
        endfunction
    endclass

    steering_predictor pred = new();

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t mismatch:%s", $realtime, msg);
    endtask

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        string msg;
        if (rst_n && drive.valid && drive.ready)
        begin
            drives_seen++;
            msg = pred.check_drive(drive.data);
            if (msg != "")
                report(msg);
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int gap;
        drive.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = recv_steady ? 0 : $urandom_range(0, 11);
            if (hold_req)
            begin
                drive.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 0;
            end
            else if (gap > 0)
            begin
                drive.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            drive.ready <= 1'b1;
            do @(posedge clk); while (!drive.valid);
        end
    end

    task automatic send_pose(input logic seen, input logic [10:0] rx, input logic [10:0] ry,
                             input logic [15:0] hd);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            pose.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pose.valid <= 1'b1;
        pose.data <= {seen, rx, ry, hd};
        do @(posedge clk); while (!pose.ready);
        if (!seen)
            blind_frames++;
        else if ((pred.goal_x() - rx) * (pred.goal_x() - rx)
                 + (pred.goal_y() - ry) * (pred.goal_y() - ry)
                 < longint'(pred.radius) * pred.radius)
            arrivals_seen++;
        pred.note_pose(seen, rx, ry, hd);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.data <= {idx, value};
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        pred.write_reg(idx, value);
    endtask

    task automatic drain();
        pose.valid <= 1'b0;
        while (pred.expected_drives.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // aim near the current corner so arrivals happen often
    task automatic send_near_goal(input int spread);
        int cx, cy, px, py;
        cx = int'(pred.goal_x()) + int'($urandom_range(0, 2 * spread)) - spread;
        cy = int'(pred.goal_y()) + int'($urandom_range(0, 2 * spread)) - spread;
        px = (cx < 0) ? 0 : (cx > 2047) ? 2047 : cx;
        py = (cy < 0) ? 0 : (cy > 2047) ? 2047 : cy;
        send_pose(1'b1, 11'(px), 11'(py), 16'($urandom));
    endtask

    task automatic write_all(input logic [10:0] lx, input logic [10:0] rx,
                             input logic [10:0] ty, input logic [10:0] by,
                             input logic [10:0] rad, input logic [6:0] cs,
                             input logic [6:0] ms, input logic [5:0] ts);
        write_reg(wsc_pkg::REG_LEFT_X, {5'($urandom_range(0, 31)), lx});
        write_reg(wsc_pkg::REG_RIGHT_X, {5'($urandom_range(0, 31)), rx});
        write_reg(wsc_pkg::REG_TOP_Y, {5'($urandom_range(0, 31)), ty});
        write_reg(wsc_pkg::REG_BOTTOM_Y, {5'($urandom_range(0, 31)), by});
        write_reg(wsc_pkg::REG_ARRIVE_RADIUS, {5'($urandom_range(0, 31)), rad});
        write_reg(wsc_pkg::REG_CRUISE_SPEED, {9'($urandom_range(0, 511)), cs});
        write_reg(wsc_pkg::REG_MIN_SPEED, {9'($urandom_range(0, 511)), ms});
        write_reg(wsc_pkg::REG_TURN_STEP, {10'($urandom_range(0, 1023)), ts});
    endtask

    initial
    begin
        int pick;
        rst_n = 1'b0;
        pose.valid <= 1'b0;
        pose.data <= '0;
        cfg.valid <= 1'b0;
        cfg.data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames on the reset settings
        send_pose(1'b0, 11'd2047, 11'd2047, 16'h7FFF);
        send_pose(1'b1, 11'd0, 11'd0, 16'h0000);
        send_pose(1'b1, 11'd2047, 11'd2047, 16'h8000);
        send_pose(1'b1, 11'd2047, 11'd0, 16'h7FFF);
        send_pose(1'b1, 11'd0, 11'd2047, 16'hC000);
        send_pose(1'b1, 11'd100, 11'd200, 16'h8000);  // bearing 0 against heading -pi
        send_pose(1'b1, 11'd900, 11'd200, 16'h0000);  // goal straight behind
        send_pose(1'b1, 11'd900, 11'd200, 16'h8000);
        send_pose(1'b1, 11'd210, 11'd190, 16'h1234);  // arrive at each corner in turn
        send_pose(1'b1, 11'd1720, 11'd200, 16'h0000);
        send_pose(1'b1, 11'd1700, 11'd870, 16'h0000);
        send_pose(1'b1, 11'd200, 11'd880, 16'h0000);
        send_pose(1'b1, 11'd1000, 11'd500, 16'h0AAB);
        send_pose(1'b1, 11'd1000, 11'd500, 16'hF555);
        drain();

        // extremes: everything zero, so the pose on the corner is a zero vector
        write_all(0, 0, 0, 0, 0, 0, 0, 0);
        send_pose(1'b1, 11'd0, 11'd0, 16'h4000);
        send_pose(1'b1, 11'd5, 11'd0, 16'h0000);
        send_pose(1'b1, 11'd2047, 11'd2047, 16'h8000);
        drain();
        write_all(2047, 2047, 2047, 2047, 2047, 127, 127, 63);
        send_pose(1'b1, 11'd0, 11'd0, 16'h0000);
        send_pose(1'b1, 11'd2047, 11'd2047, 16'hFFFF);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: write_all(200, 1720, 200, 880, 100, 50, 15, 10);
                1: write_all(0, 2047, 0, 2047, 2047, 127, 0, 63);
                2: write_all(300, 700, 300, 700, 0, 0, 0, 0);
                3: write_all(0, 2047, 2047, 0, 40, 127, 127, 0);
                default: write_all(11'($urandom), 11'($urandom), 11'($urandom),
                                   11'($urandom), 11'($urandom_range(0, 300)),
                                   7'($urandom), 7'($urandom), 6'($urandom));
            endcase
            send_steady = (ph % 3 == 1);
            recv_steady = (ph % 3 == 2);
            if (ph == 0)
            begin
                send_steady = 1;
                hold_req = 1;
            end
            for (int n = 0; n < 130; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    send_near_goal(int'(pred.radius) + 3);
                else if (pick < 40)
                    send_pose(1'b0, 11'($urandom), 11'($urandom), 16'($urandom));
                else
                    send_pose(1'b1, 11'($urandom), 11'($urandom), 16'($urandom));
            end
            drain();
        end

        $display("frames: %0d drive words checked, %0d arrivals, %0d without a pose",
                 drives_seen, arrivals_seen, blind_frames);
        $display("settings: reset, all-zero, all-max and %0d further register sets", PHASES);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
